/* src/kwm_pkg.sv */
// Shared types, widths and controller codes for the k-way sorted merge block.
package kwm_pkg;

  localparam int DATA_W     = 32;
  localparam int LIST_NUM_W = 4;
  localparam int ACTIVE_W   = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_TAKE = 1'b1;

  typedef struct packed {
    logic                     action;
    logic [LIST_NUM_W-1:0]    list_number;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic [LIST_NUM_W-1:0]    out_list;
    logic                     got_element;
    logic                     load_refused;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_TAKE_SCAN,
    ST_TAKE_DRAIN,
    ST_TAKE_WR
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic meta_load_sel;
    logic scan_issue;
    logic load_commit;
    logic take_commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic pipe_empty;
    logic out_free;
  } sts_t;

endpackage

/* src/kwm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/kwm_ctrl.sv */
// Controller state machine: sequences loads, head scans and write-back.
module kwm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  input  logic          item_take,
  output logic          item_ready,
  input  kwm_pkg::sts_t sts,
  output kwm_pkg::cmd_t cmd
);

  kwm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      kwm_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = (item_take == kwm_pkg::ACTION_TAKE) ? kwm_pkg::ST_TAKE_SCAN
                                                            : kwm_pkg::ST_LOAD_RD;
        end
      end
      kwm_pkg::ST_LOAD_RD: begin
        cmd.meta_load_sel = 1'b1;
        state_next        = kwm_pkg::ST_LOAD_WR;
      end
      kwm_pkg::ST_LOAD_WR: begin
        cmd.meta_load_sel = 1'b1;
        if (sts.out_free) begin
          cmd.load_commit = 1'b1;
          state_next      = kwm_pkg::ST_IDLE;
        end
      end
      kwm_pkg::ST_TAKE_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = kwm_pkg::ST_TAKE_DRAIN;
        end
      end
      kwm_pkg::ST_TAKE_DRAIN: begin
        if (sts.pipe_empty) begin
          state_next = kwm_pkg::ST_TAKE_WR;
        end
      end
      kwm_pkg::ST_TAKE_WR: begin
        if (sts.out_free) begin
          cmd.take_commit = 1'b1;
          state_next      = kwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kwm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/kwm_dpath.sv */
// Datapath: list metadata and element memories, head scan pipeline, result register.
module kwm_dpath #(
  parameter int LISTS      = 16,
  parameter int LIST_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  kwm_pkg::cmd_t                  cmd,
  output kwm_pkg::sts_t                  sts,
  input  logic [kwm_pkg::ACTIVE_W-1:0]   active_lists,
  input  kwm_pkg::in_t                   item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output kwm_pkg::out_t                  result
);

  localparam int LW     = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int CW     = $clog2(LISTS + 1);
  localparam int HW     = $clog2(LIST_DEPTH);
  localparam int PW     = HW + 1;
  localparam int FW     = $clog2(LIST_DEPTH + 1);
  localparam int MW     = HW + FW;
  localparam int EDEPTH = LISTS * LIST_DEPTH;
  localparam int EAW    = $clog2(EDEPTH);
  localparam int DW     = kwm_pkg::DATA_W;

  // captured item
  logic [kwm_pkg::LIST_NUM_W-1:0] it_list;
  logic signed [DW-1:0]           it_value;

  // scan pipeline
  logic [CW-1:0]        si;
  logic                 s1_valid;
  logic [LW-1:0]        s1_idx;
  logic                 s2_valid;
  logic [LW-1:0]        s2_idx;
  logic [HW-1:0]        s2_head;
  logic [FW-1:0]        s2_fill;
  logic                 found;
  logic [LW-1:0]        best_idx;
  logic signed [DW-1:0] best_val;
  logic [HW-1:0]        best_head;
  logic [FW-1:0]        best_fill;

  // metadata storage
  logic [LISTS-1:0] meta_vld;
  logic             meta_rd_vld;
  logic [LW-1:0]    meta_raddr;
  logic [MW-1:0]    meta_rdata;
  logic             meta_we;
  logic [LW-1:0]    meta_waddr;
  logic [MW-1:0]    meta_wdata;

  logic [EAW-1:0]   elem_raddr;
  logic [EAW-1:0]   elem_waddr;
  logic [DW-1:0]    elem_rdata;
  logic             elem_we;

  logic [CW-1:0]    act_eff;
  logic [LW-1:0]    lst_idx;
  logic             list_ok;
  logic [HW-1:0]    rd_head;
  logic [FW-1:0]    rd_fill;
  logic             full;
  logic             load_ok;
  logic [PW-1:0]    pos_sum;
  logic [HW-1:0]    pos;
  logic [HW-1:0]    best_head_inc;

  always_comb begin
    act_eff  = (32'(active_lists) > LISTS) ? CW'(LISTS) : CW'(active_lists);
    lst_idx  = LW'(it_list);
    list_ok  = 32'(it_list) < 32'(act_eff);
    meta_raddr = cmd.meta_load_sel ? lst_idx : si[LW-1:0];
    rd_head  = meta_rd_vld ? meta_rdata[MW-1:FW] : '0;
    rd_fill  = meta_rd_vld ? meta_rdata[FW-1:0] : '0;
    full     = 32'(rd_fill) >= LIST_DEPTH;
    load_ok  = list_ok && !full;
    pos_sum  = PW'(rd_head) + PW'(rd_fill);
    pos      = (32'(pos_sum) >= LIST_DEPTH) ? HW'(pos_sum - PW'(LIST_DEPTH)) : HW'(pos_sum);
    elem_waddr = EAW'(lst_idx) * EAW'(LIST_DEPTH) + EAW'(pos);
    elem_raddr = EAW'(s1_idx) * EAW'(LIST_DEPTH) + EAW'(rd_head);
    elem_we    = cmd.load_commit && load_ok;
    best_head_inc = (32'(best_head) == LIST_DEPTH - 1) ? '0 : best_head + 1'b1;
    meta_we    = (cmd.load_commit && load_ok) || (cmd.take_commit && found);
    meta_waddr = cmd.load_commit ? lst_idx : best_idx;
    meta_wdata = cmd.load_commit ? {rd_head, FW'(rd_fill + 1'b1)}
                                 : {best_head_inc, FW'(best_fill - 1'b1)};
    sts.scan_last  = (32'(si) + 1) >= 32'(act_eff);
    sts.pipe_empty = !s1_valid && !s2_valid;
    sts.out_free   = !result_valid || result_ready;
  end

  kwm_ram #(.WIDTH(MW), .DEPTH(LISTS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  kwm_ram #(.WIDTH(DW), .DEPTH(EDEPTH)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (it_value),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_vld    <= '0;
      meta_rd_vld <= 1'b0;
    end else begin
      meta_rd_vld <= meta_vld[meta_raddr];
      if (meta_we) begin
        meta_vld[meta_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_list  <= item.list_number;
      it_value <= item.value;
    end
  end

  // scan pipeline: issue metadata read, then element read, then compare
  always_ff @(posedge clk) begin
    if (rst) begin
      si       <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      found    <= 1'b0;
    end else begin
      s1_valid <= 1'b0;
      if (cmd.capture) begin
        si    <= '0;
        found <= 1'b0;
      end else if (cmd.scan_issue && (si < act_eff)) begin
        s1_valid <= 1'b1;
        si       <= si + 1'b1;
      end
      s2_valid <= s1_valid && (rd_fill != '0);
      if (s2_valid && (!found || ($signed(elem_rdata) <= best_val))) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= si[LW-1:0];
    s2_idx  <= s1_idx;
    s2_head <= rd_head;
    s2_fill <= rd_fill;
    if (s2_valid && (!found || ($signed(elem_rdata) <= best_val))) begin
      best_idx  <= s2_idx;
      best_val  <= $signed(elem_rdata);
      best_head <= s2_head;
      best_fill <= s2_fill;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_commit || cmd.take_commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_commit) begin
      result.out_value    <= '0;
      result.out_list     <= '0;
      result.got_element  <= 1'b0;
      result.load_refused <= !load_ok;
    end else if (cmd.take_commit) begin
      result.out_value    <= found ? best_val : '0;
      result.out_list     <= found ? kwm_pkg::LIST_NUM_W'(best_idx) : '0;
      result.got_element  <= found;
      result.load_refused <= 1'b0;
    end
  end

endmodule

/* src/k_way_sorted_merge.sv */
// Top level of the k-way sorted merge: APB register, controller and datapath.
//
// Keeps up to LISTS first-in first-out queues of signed 32-bit values, each
// a circular region of LIST_DEPTH slots in one element memory. A load
// request appends its value to a list; it is refused when the list is full
// or numbered at or above the active count. A take request removes the
// smallest head among the active lists (ties go to the higher list number):
// the scan reads one list's head offset and fill and then its head element
// per cycle, pipelined through the single read port of the metadata and
// element memories, and the winner is written back at the end. Either
// request stalls further while the previous result still waits, and the
// controller returns to idle before it accepts the next request.
// One request is in flight at a time; a finished result waits in an output
// register while the next request is accepted. The element memory needs no
// clearing pass: only data from written slots is used, and the per-list metadata
// reads as zero after reset through valid bits. active_lists is register 0
// at byte address 0, resets to 16 and saturates at LISTS; write it only while idle.
module k_way_sorted_merge #(
  parameter int LISTS      = 16,
  parameter int LIST_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  kwm_pkg::in_t                     item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output kwm_pkg::out_t                    result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kwm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [kwm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [kwm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic [kwm_pkg::ACTIVE_W-1:0] active_lists;
  logic                         cfg_wr;
  kwm_pkg::cmd_t                cmd;
  kwm_pkg::sts_t                sts;

  // register index comes from paddr[2]; only index 0 exists
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? '0 : kwm_pkg::APB_DATA_W'(active_lists);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_lists <= kwm_pkg::ACTIVE_W'(16);
    end else if (cfg_wr) begin
      active_lists <= pwdata[kwm_pkg::ACTIVE_W-1:0];
    end
  end

  kwm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_take  (item.action),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  kwm_dpath #(
    .LISTS      (LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .active_lists (active_lists),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // one request at a time: acceptance drops ready on the next cycle
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request accepted while another is in flight");

  // a result never both returns an element and flags a refused load
  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.got_element && result.load_refused))
    else $error("result flags conflict");

  // a register write lands in active_lists on the next cycle
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> active_lists == $past(pwdata[kwm_pkg::ACTIVE_W-1:0]))
    else $error("active_lists write lost");

endmodule

/* test/k_way_sorted_merge_tb.sv */
// Self-checking testbench for the k-way sorted merge: directed and random requests.
`timescale 1ns / 1ps

module k_way_sorted_merge_tb;

  localparam int LISTS        = 16;
  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 285;
  localparam int CYCLE_LIMIT  = 500000;
  // Settle time after the last result.
  localparam int SETTLE       = LISTS + 8;

  localparam logic [kwm_pkg::APB_ADDR_W-1:0] ADDR_ACTIVE_LISTS = '0;

  // Mirrors the list memory and metadata; computes one expected result per
  // accepted request and checks results in arrival order.
  class merge_scoreboard;
    logic signed [kwm_pkg::DATA_W-1:0] slots [LISTS][LIST_DEPTH];
    logic [5:0]                        head [LISTS];
    logic [6:0]                        fill [LISTS];
    logic [kwm_pkg::ACTIVE_W-1:0]      active;
    kwm_pkg::out_t                     merge_results_due [$];
    int errors, loads_kept, loads_refused, takes_hit, takes_empty, checked;

    function new();
      for (int i = 0; i < LISTS; i++) begin
        head[i] = '0;
        fill[i] = '0;
      end
      active = 5'd16;
      errors = 0;
      loads_kept = 0;
      loads_refused = 0;
      takes_hit = 0;
      takes_empty = 0;
      checked = 0;
    endfunction

    function void set_active(logic [kwm_pkg::ACTIVE_W-1:0] count);
      active = count;
    endfunction

    // Active count saturates at the number of lists.
    function int live_lists();
      return (active > LISTS) ? LISTS : int'(active);
    endfunction

    function int pending();
      return merge_results_due.size();
    endfunction

    function void note_request(kwm_pkg::in_t req);
      kwm_pkg::out_t                     res;
      int                                lim;
      int                                best;
      bit                                found;
      logic signed [kwm_pkg::DATA_W-1:0] best_val;
      logic signed [kwm_pkg::DATA_W-1:0] h;
      logic [5:0]                        tail;
      res = '0;
      lim = live_lists();
      found = 1'b0;
      best = 0;
      best_val = '0;
      if (req.action == kwm_pkg::ACTION_LOAD) begin
        // Refuse loads into inactive or full lists; state stays untouched.
        if (int'(req.list_number) >= lim || fill[req.list_number] >= LIST_DEPTH) begin
          res.load_refused = 1'b1;
          loads_refused++;
        end else begin
          tail = head[req.list_number] + fill[req.list_number][5:0];
          slots[req.list_number][tail] = req.value;
          fill[req.list_number]++;
          loads_kept++;
        end
      end else begin
        // Scan active heads; on equal values the later (higher) list wins.
        for (int i = 0; i < lim; i++) begin
          if (fill[i] != 0) begin
            h = slots[i][head[i]];
            if (!found || h <= best_val) begin
              found = 1'b1;
              best = i;
              best_val = h;
            end
          end
        end
        if (found) begin
          head[best]++;
          fill[best]--;
          res.out_value = best_val;
          res.out_list = best[kwm_pkg::LIST_NUM_W-1:0];
          res.got_element = 1'b1;
          takes_hit++;
        end else begin
          takes_empty++;
        end
      end
      merge_results_due.push_back(res);
    endfunction

    function void check_result(kwm_pkg::out_t got);
      kwm_pkg::out_t want;
      if (merge_results_due.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        errors++;
        return;
      end
      want = merge_results_due.pop_front();
      checked++;
      if (got.out_value !== want.out_value) begin
        $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
        errors++;
      end
      if (got.out_list !== want.out_list) begin
        $error("out_list: expected %0d, got %0d", want.out_list, got.out_list);
        errors++;
      end
      if (got.got_element !== want.got_element) begin
        $error("got_element: expected %0b, got %0b", want.got_element, got.got_element);
        errors++;
      end
      if (got.load_refused !== want.load_refused) begin
        $error("load_refused: expected %0b, got %0b", want.load_refused, got.load_refused);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           item_valid = 1'b0;
  logic                           item_ready;
  kwm_pkg::in_t                   item = '0;
  logic                           result_valid;
  logic                           result_ready = 1'b1;
  kwm_pkg::out_t                  result;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [kwm_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [kwm_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [kwm_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  merge_scoreboard board = new();
  int              burst_left = 0;
  int              random_sent = 0;
  int              drain_pauses = 0;
  int              cycles = 0;
  int              stall_mode = 0;
  int              stall_left = 0;

  k_way_sorted_merge #(
    .LISTS      (LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check every result the moment it is taken.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      board.check_result(result);
    end
  end

  // Receiver back-pressure: switch between always-ready, coin-flip, sparse
  // and long-stall patterns for random stretches.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        result_ready <= 1'b1;
      end
      1: begin
        result_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        result_ready <= ($urandom_range(0, 5) == 0);
      end
      default: begin
        result_ready <= (stall_left % 16 == 0);
      end
    endcase
  end

  // Present one request and hold it until accepted. Requests go out in
  // bursts; between bursts valid may drop for a random gap.
  task automatic send_request(input kwm_pkg::in_t req);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= req;
    do @(posedge clk); while (!item_ready);
    board.note_request(req);
  endtask

  // Drop valid and hold off until every expected result is back.
  task automatic hold_until_drained(input int settle);
    @(negedge clk);
    item_valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Two-phase register write; only called while the block is idle.
  task automatic write_active_lists(input logic [kwm_pkg::ACTIVE_W-1:0] count);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ACTIVE_LISTS;
    pwdata <= kwm_pkg::APB_DATA_W'(count);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_active(count);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load(input int lst, input logic signed [kwm_pkg::DATA_W-1:0] val);
    kwm_pkg::in_t req;
    req.action = kwm_pkg::ACTION_LOAD;
    req.list_number = lst[kwm_pkg::LIST_NUM_W-1:0];
    req.value = val;
    send_request(req);
  endtask

  task automatic take();
    kwm_pkg::in_t req;
    req.action = kwm_pkg::ACTION_TAKE;
    req.list_number = kwm_pkg::LIST_NUM_W'($urandom_range(0, 15));
    req.value = $urandom();
    send_request(req);
  endtask

  // One merge round: nondecreasing runs into random active lists, sprinkled
  // with noise, then enough takes to empty what was loaded and a bit more.
  task automatic merge_round();
    logic signed [kwm_pkg::DATA_W-1:0] run_tail [LISTS];
    int           lim, n, spread, lst;
    kwm_pkg::in_t req;
    lim = board.live_lists();
    n = $urandom_range(3, 14);
    // Narrow steps make equal heads (and tie-breaks) common.
    spread = ($urandom_range(0, 2) == 0) ? 2 : 1000;
    for (int i = 0; i < LISTS; i++) begin
      run_tail[i] = $urandom();
    end
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 9) == 0) begin
        req.action = 1'($urandom_range(0, 1));
        req.list_number = kwm_pkg::LIST_NUM_W'($urandom_range(0, 15));
        req.value = $urandom();
        send_request(req);
      end else begin
        lst = (lim == 0) ? $urandom_range(0, 15) : $urandom_range(0, lim - 1);
        run_tail[lst] = run_tail[lst] + $urandom_range(0, spread);
        load(lst, run_tail[lst]);
      end
      random_sent++;
    end
    if ($urandom_range(0, 7) == 0) begin
      hold_until_drained(0);
      drain_pauses++;
    end
    repeat (n + $urandom_range(0, 2)) begin
      take();
      random_sent++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty take, field extremes, ties between equal heads.
    take();
    load(0, 32'sh8000_0000);
    load(15, 32'sh7fff_ffff);
    load(3, 0);
    load(7, -1);
    load(3, -1);
    load(9, -1);
    repeat (6) take();
    take();
    load(15, 32'sh5555_5555);
    load(10, 32'shAAAA_AAAA);
    take();
    take();

    // No list active: every load refused, every take empty.
    hold_until_drained(SETTLE);
    write_active_lists(5'd0);
    load(0, 5);
    load(15, -5);
    take();

    // Count above the list total saturates; park a value in list 5.
    hold_until_drained(SETTLE);
    write_active_lists(5'd31);
    load(15, 5);
    take();
    load(5, 42);

    // Single list: fill it past capacity, loads elsewhere refused, and the
    // parked value in list 5 is ignored by takes.
    hold_until_drained(SETTLE);
    write_active_lists(5'd1);
    for (int i = 0; i < LIST_DEPTH + 2; i++) begin
      load(0, i - 32);
    end
    load(5, 7);
    repeat (LIST_DEPTH + 2) take();

    // All lists back: the parked value comes out.
    hold_until_drained(SETTLE);
    write_active_lists(5'd16);
    take();

    // Random phases, each under its own active count.
    while (random_sent < RANDOM_ITEMS) begin
      hold_until_drained(SETTLE);
      write_active_lists(($urandom_range(0, 2) != 0) ? 5'd16 : 5'($urandom_range(0, 31)));
      repeat ($urandom_range(3, 8)) begin
        if (random_sent < RANDOM_ITEMS) begin
          merge_round();
        end
      end
    end

    hold_until_drained(SETTLE);
    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      board.errors++;
    end

    $display("checked %0d results: %0d loads kept, %0d refused, %0d takes hit, %0d empty",
             board.checked, board.loads_kept, board.loads_refused,
             board.takes_hit, board.takes_empty);
    $display("%0d random requests, %0d drain pauses, %0d cycles",
             random_sent, drain_pauses, cycles);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
